>>> rtl/qkb_pkg.sv
// ----------------------------------------------------------------------------
// qkb_pkg
// Shared types and constants of the quadrature knob with mode button.
// ----------------------------------------------------------------------------
`default_nettype none

package qkb_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LONG_PRESS      = 2'd0,
        CFG_VOLUME_STEP     = 2'd1,
        CFG_BRIGHTNESS_STEP = 2'd2
    } qkb_cfg_index_t;

    localparam int THRESH_W = 24;
    localparam int STEP_W   = 7;
    localparam int DELTA_W  = 8;

    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 24'd1000000;
    localparam logic [STEP_W-1:0]   STEP_RESET       = 7'd5;

    // idle level of both encoder pins
    localparam logic [1:0] AB_IDLE = 2'b11;

    // transition code {previous A, previous B, A, B}: one bit per code
    localparam logic [15:0] CW_CODES  = 16'h4182;  // 0x1 0x7 0x8 0xE
    localparam logic [15:0] CCW_CODES = 16'h2814;  // 0x2 0x4 0xB 0xD

    // configuration as seen by the datapath
    typedef struct packed {
        logic [THRESH_W-1:0] long_press_ticks;
        logic [STEP_W-1:0]   volume_step;
        logic [STEP_W-1:0]   brightness_step;
    } qkb_cfg_t;

    // one result item
    typedef struct packed {
        logic                      step_valid;
        logic signed [DELTA_W-1:0] step_delta;
        logic                      step_is_volume;
        logic                      mode_toggled;
        logic                      long_press;
        logic                      volume_mode;
    } qkb_result_t;

    // x4 quadrature direction of one transition
    function automatic logic signed [1:0] qkb_dir(input logic [3:0] code);
        logic signed [1:0] dir;
        dir = 2'sd0;
        if (CW_CODES[code])
            dir = 2'sd1;
        else if (CCW_CODES[code])
            dir = -2'sd1;
        return dir;
    endfunction

endpackage

`default_nettype wire

>>> rtl/qkb_engine.sv
// ----------------------------------------------------------------------------
// qkb_engine
// Per-sample state and result logic: quadrature decode, detent
// accumulation, press timing and mode handling.
// ----------------------------------------------------------------------------
`default_nettype none

module qkb_engine
    import qkb_pkg::*;
#(
    parameter int DETENT_COUNT = 4,
    parameter int HOLD_WIDTH   = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        pin_a,
    input  wire logic        pin_b,
    input  wire logic        button_level,
    input  wire qkb_cfg_t    cfg,
    output qkb_result_t      result
);

    localparam int ACC_W = $clog2(DETENT_COUNT + 1) + 1;
    localparam int CMP_W = (HOLD_WIDTH > THRESH_W) ? HOLD_WIDTH : THRESH_W;
    localparam logic signed [ACC_W-1:0] DET_POS = ACC_W'(DETENT_COUNT);
    localparam logic signed [ACC_W-1:0] DET_NEG = -DET_POS;
    localparam logic [HOLD_WIDTH-1:0]   HOLD_MAX = {HOLD_WIDTH{1'b1}};

    logic [1:0]              prev_ab_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    mode_reg, mode_next;
    logic                    held_reg, held_next;
    logic [HOLD_WIDTH-1:0]   hold_reg, hold_next;

    logic [1:0]              cur_ab;
    logic signed [1:0]       dir;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    step;
    logic [STEP_W-1:0]       size;
    logic [HOLD_WIDTH-1:0]   hold_inc;
    logic                    is_long;
    logic                    toggled;
    logic                    long_pulse;

    // quadrature decode and detent accumulation
    always_comb
    begin
        cur_ab   = {pin_a, pin_b};
        dir      = qkb_dir({prev_ab_reg, cur_ab});
        acc_sum  = acc_reg + $signed(ACC_W'(dir));
        step     = (acc_sum <= DET_NEG) || (acc_sum >= DET_POS);
        acc_next = step ? '0 : acc_sum;
        size     = mode_reg ? cfg.volume_step : cfg.brightness_step;
    end

    // press timing and mode
    always_comb
    begin
        hold_inc   = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
        is_long    = CMP_W'(hold_inc) >= CMP_W'(cfg.long_press_ticks);
        held_next  = held_reg;
        hold_next  = hold_reg;
        mode_next  = mode_reg;
        toggled    = 1'b0;
        long_pulse = 1'b0;
        if (held_reg)
        begin
            hold_next = hold_inc;
            if (button_level)
            begin
                held_next = 1'b0;
                hold_next = '0;
                if (is_long)
                begin
                    long_pulse = 1'b1;
                end
                else
                begin
                    toggled   = 1'b1;
                    mode_next = !mode_reg;
                end
            end
        end
        else if (!button_level)
        begin
            held_next = 1'b1;
            hold_next = '0;
        end
    end

    // result item; the step uses the mode from before any toggle
    always_comb
    begin
        result.step_valid     = step;
        result.step_is_volume = step && mode_reg;
        if (!step)
            result.step_delta = '0;
        else if (acc_sum < 0)
            result.step_delta = $signed({1'b0, size});
        else
            result.step_delta = -$signed({1'b0, size});
        result.mode_toggled   = toggled;
        result.long_press     = long_pulse;
        result.volume_mode    = mode_next;
    end

    // state update per transferred sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg <= AB_IDLE;
            acc_reg     <= '0;
            mode_reg    <= 1'b1;
            held_reg    <= 1'b0;
            hold_reg    <= '0;
        end
        else if (advance)
        begin
            prev_ab_reg <= cur_ab;
            acc_reg     <= acc_next;
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/quadrature_knob_with_mode_button_core.sv
// Path: a sample transfer loads the input register; the engine's result is then
// captured in the result register and offered from there.
// Throughput: one sample per cycle while the output is not stalled, set by
// the single-pass decode between input and result registers; a stalled output
// holds its result. Reset (rst_n low, asynchronous) empties both registers and
// restores the configuration and knob state to their reset values.
// ----------------------------------------------------------------------------
// quadrature_knob_with_mode_button_core
// Top level: input register, configuration registers, result register and
// handshakes around the per-sample engine.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_knob_with_mode_button_core
    import qkb_pkg::*;
#(
    parameter int DETENT_COUNT = 4,
    parameter int HOLD_WIDTH   = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // sample input
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               pin_a,
    input  wire logic               pin_b,
    input  wire logic               button_level,
    // result output
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    step_valid,
    output logic signed [7:0]       step_delta,
    output logic                    step_is_volume,
    output logic                    mode_toggled,
    output logic                    long_press,
    output logic                    volume_mode,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    logic        s1_valid_reg, s1_valid_next;
    logic        a_reg, b_reg, btn_reg;
    logic        out_valid_reg, out_valid_next;
    qkb_result_t result_reg;
    qkb_result_t result;
    qkb_cfg_t    cfg_reg;
    logic        advance;

    // handshake control
    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || advance;
        s1_valid_next  = in_valid ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        if (!in_ready)
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign cfg_ready = 1'b1;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg   <= pin_a;
            b_reg   <= pin_b;
            btn_reg <= button_level;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.volume_step      <= STEP_RESET;
            cfg_reg.brightness_step  <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:      cfg_reg.long_press_ticks <= cfg_data;
                CFG_VOLUME_STEP:     cfg_reg.volume_step      <= cfg_data[STEP_W-1:0];
                CFG_BRIGHTNESS_STEP: cfg_reg.brightness_step  <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    qkb_engine #(
        .DETENT_COUNT (DETENT_COUNT),
        .HOLD_WIDTH   (HOLD_WIDTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .pin_a        (a_reg),
        .pin_b        (b_reg),
        .button_level (btn_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    // outputs
    assign out_valid      = out_valid_reg;
    assign step_valid     = result_reg.step_valid;
    assign step_delta     = result_reg.step_delta;
    assign step_is_volume = result_reg.step_is_volume;
    assign mode_toggled   = result_reg.mode_toggled;
    assign long_press     = result_reg.long_press;
    assign volume_mode    = result_reg.volume_mode;

endmodule

`default_nettype wire

>>> rtl/qkb_checker.sv
// ----------------------------------------------------------------------------
// qkb_checker
// Port-level checks on the knob core's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module qkb_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              step_valid,
    input  wire logic signed [7:0] step_delta,
    input  wire logic              step_is_volume,
    input  wire logic              mode_toggled,
    input  wire logic              long_press,
    input  wire logic              volume_mode
);

    // a stalled result stays offered with its step, delta and mode unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_delta)
            && $stable(step_valid) && $stable(volume_mode))
        else $error("stalled result changed");

    // no step means no delta and no target
    a_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !step_valid |-> step_delta == 8'sd0 && !step_is_volume)
        else $error("delta or target without a step");

    // one release is either short or long, never both
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(mode_toggled && long_press))
        else $error("short and long press in one result");

    // a transfer into an empty core shows its result from the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result missing after sample transfer");

endmodule

bind quadrature_knob_with_mode_button_core qkb_checker u_qkb_checker (.*);

`default_nettype wire

>>> dv/tb_quadrature_knob_with_mode_button_core.sv
// ----------------------------------------------------------------------------
// tb_quadrature_knob_with_mode_button_core
// Self-checking bench for the quadrature knob with mode button. A short
// stimulus table covers detents in both senses, invalid pin jumps, short and
// long presses and register extremes. Random phases then replay gray-code
// rotation with button presses timed around the threshold. Every result
// transfer is checked against the typed result or an in-bench model of the
// decoder, while both handshakes idle in bursts and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadrature_knob_with_mode_button_core
    import qkb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DETENT_STEPS = 4;
    localparam int PHASE_ITEMS  = 275;
    localparam int DRAIN_LIMIT  = 20000;

    // pin levels {A, B} in clockwise order
    localparam logic [1:0] GRAY_AB [4] = '{AB_IDLE, 2'b10, 2'b00, 2'b01};

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_MASK
    } rx_style_t;

    typedef struct packed {
        row_kind_t      kind;
        logic           a;
        logic           b;
        logic           btn;
        qkb_cfg_index_t idx;
        logic [23:0]    data;
        logic           typed;
        qkb_result_t    res;
    } knob_row_t;

    localparam qkb_result_t IDLE_VOL = '{1'b0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b1};

    // directed stimulus: results typed in only where obvious
    localparam int DIRECTED_LEN = 30;
    localparam knob_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1, IDLE_VOL},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b0, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b1, 8'sd5, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_SAMPLE, 1'b1, 1'b0, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b1, -8'sd5, 1'b1, 1'b0, 1'b0, 1'b1}},
        // both pins jump and jump back: no movement
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1, IDLE_VOL},
        // short press with a repeated low level
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b0, 8'sd0, 1'b0, 1'b1, 1'b0, 1'b0}},
        // detent and release in one tick: step keeps the old mode
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b1, 8'sd5, 1'b0, 1'b1, 1'b0, 1'b1}},
        // zero threshold, largest step with upper data bits set, zero step
        '{ROW_WRITE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_WRITE, 1'b1, 1'b1, 1'b1, CFG_VOLUME_STEP, 24'hFFFFFF, 1'b0, '0},
        '{ROW_WRITE, 1'b1, 1'b1, 1'b1, CFG_BRIGHTNESS_STEP, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b1, -8'sd127, 1'b1, 1'b0, 1'b1, 1'b1}},
        // threshold at its maximum: a release before the hold count saturates toggles
        '{ROW_WRITE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'hFFFFFF, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b0, 1'b0, CFG_LONG_PRESS, 24'd0, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 1'b1, 1'b1, CFG_LONG_PRESS, 24'd0, 1'b1,
          '{1'b1, 8'sd127, 1'b1, 1'b1, 1'b0, 1'b0}}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                pin_a;
    logic                pin_b;
    logic                button_level;
    logic                out_valid;
    logic                out_ready;
    logic                step_valid;
    logic signed [7:0]   step_delta;
    logic                step_is_volume;
    logic                mode_toggled;
    logic                long_press;
    logic                volume_mode;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [23:0]         cfg_data;

    // decoder model state and configuration
    logic [1:0]          knob_prev_ab;
    logic signed [3:0]   knob_acc;
    logic                knob_vol_mode;
    logic                knob_held;
    logic [23:0]         knob_hold_cnt;
    logic [23:0]         cfg_thresh;
    logic [6:0]          cfg_vol_step;
    logic [6:0]          cfg_bri_step;

    qkb_result_t         pending_results [$];
    int                  mismatch_count;
    int                  samples_taken;
    int                  burst_left;

    // random walk over the gray sequence and button timing
    logic [1:0]          walk_pos;
    logic [1:0]          walk_dir;
    logic                btn_low;
    int                  btn_run;

    // receiver stall control
    logic                hold_off;
    rx_style_t           rx_style;
    int                  rx_left;
    logic [15:0]         rx_mask;

    quadrature_knob_with_mode_button_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pin_a          (pin_a),
        .pin_b          (pin_b),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .step_valid     (step_valid),
        .step_delta     (step_delta),
        .step_is_volume (step_is_volume),
        .mode_toggled   (mode_toggled),
        .long_press     (long_press),
        .volume_mode    (volume_mode),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one sample through the decoder model
    function automatic qkb_result_t knob_predict(input logic a, input logic b,
                                                 input logic btn);
        qkb_result_t res;
        logic [1:0]  cur_ab;
        logic [1:0]  move;
        logic [6:0]  size;
        res    = '0;
        cur_ab = {a, b};
        // position along the gray sequence is {~A, A^B}; one step either way counts
        move = {~cur_ab[1], ^cur_ab} - {~knob_prev_ab[1], ^knob_prev_ab};
        if (move == 2'd1)
            knob_acc = knob_acc + 4'sd1;
        else if (move == 2'd3)
            knob_acc = knob_acc - 4'sd1;
        // full detent: inverted sense, size from the mode before any toggle
        if (knob_acc <= -DETENT_STEPS || knob_acc >= DETENT_STEPS)
        begin
            size               = knob_vol_mode ? cfg_vol_step : cfg_bri_step;
            res.step_valid     = 1'b1;
            res.step_is_volume = knob_vol_mode;
            res.step_delta     = (knob_acc < 0) ? $signed({1'b0, size})
                                                : -$signed({1'b0, size});
            knob_acc           = '0;
        end
        knob_prev_ab = cur_ab;
        // press timing, saturating, release tick included
        if (knob_held)
        begin
            if (knob_hold_cnt != '1)
                knob_hold_cnt = knob_hold_cnt + 24'd1;
            if (btn)
            begin
                knob_held = 1'b0;
                if (knob_hold_cnt >= cfg_thresh)
                    res.long_press = 1'b1;
                else
                begin
                    knob_vol_mode    = ~knob_vol_mode;
                    res.mode_toggled = 1'b1;
                end
                knob_hold_cnt = '0;
            end
        end
        else if (!btn)
        begin
            knob_held     = 1'b1;
            knob_hold_cnt = '0;
        end
        res.volume_mode = knob_vol_mode;
        return res;
    endfunction

    // one sample transfer, with the sender's bursts and gaps
    task automatic send_sample(input logic a, input logic b, input logic btn,
                               input logic typed, input qkb_result_t typed_res);
        qkb_result_t predicted;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid     <= 1'b1;
        pin_a        <= a;
        pin_b        <= b;
        button_level <= btn;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = knob_predict(a, b, btn);
        pending_results.push_back(typed ? typed_res : predicted);
        samples_taken++;
        burst_left--;
        @(negedge clk);
    endtask

    // register write once every outstanding result has come back
    task automatic write_reg(input qkb_cfg_index_t idx, input logic [23:0] data);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LONG_PRESS:      cfg_thresh   = data;
            CFG_VOLUME_STEP:     cfg_vol_step = data[6:0];
            CFG_BRIGHTNESS_STEP: cfg_bri_step = data[6:0];
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one configuration setting followed by random rotation and presses
    task automatic run_phase(input logic [23:0] thresh, input logic [23:0] vol,
                             input logic [23:0] bri, input int items);
        int         press_max;
        int         pick;
        logic [1:0] ab;
        write_reg(CFG_LONG_PRESS, thresh);
        write_reg(CFG_VOLUME_STEP, vol);
        write_reg(CFG_BRIGHTNESS_STEP, bri);
        // press lengths straddle the threshold where it is reachable
        press_max = (thresh < 40) ? 2 * thresh + 3 : 40;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                walk_pos = 2'($urandom_range(0, 3));
            else if (pick < 65)
                walk_pos = walk_pos + walk_dir;
            else if (pick < 75)
                walk_pos = walk_pos - walk_dir;
            if ($urandom_range(0, 47) == 0)
                walk_dir = -walk_dir;
            if (btn_run == 0)
            begin
                btn_low = ~btn_low;
                btn_run = btn_low ? $urandom_range(1, press_max)
                                  : $urandom_range(1, 12);
            end
            btn_run--;
            ab = GRAY_AB[walk_pos];
            send_sample(ab[1], ab[0], ~btn_low, 1'b0, '0);
        end
    endtask

    // receiver: stall style changes now and then, plus the long hold-off
    initial
    begin
        out_ready = 1'b0;
        rx_style  = RX_FREE;
        rx_left   = 0;
        rx_mask   = 16'hFFFF;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 2));
                rx_left  = $urandom_range(20, 200);
                rx_mask  = 16'($urandom);
            end
            rx_left--;
            rx_mask = {rx_mask[14:0], rx_mask[15]};
            if (hold_off)
                out_ready <= 1'b0;
            else
                case (rx_style)
                    RX_FREE: out_ready <= 1'b1;
                    RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= rx_mask[0];
                endcase
        end
    end

    // long receiver hold-off while the sender keeps offering samples
    initial
    begin
        hold_off = 1'b0;
        wait (samples_taken >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin : check_results
        qkb_result_t want;
        qkb_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{step_valid, step_delta, step_is_volume, mode_toggled,
                    long_press, volume_mode};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.step_valid !== want.step_valid
                    || got.step_delta !== want.step_delta
                    || got.step_is_volume !== want.step_is_volume
                    || got.mode_toggled !== want.mode_toggled
                    || got.long_press !== want.long_press
                    || got.volume_mode !== want.volume_mode)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("%0t: expected step %0b delta %0d vol %0b toggle %0b ",
                               $realtime, want.step_valid, want.step_delta,
                               want.step_is_volume, want.mode_toggled);
                        $display("long %0b mode %0b, got %0b %0d %0b %0b %0b %0b",
                                 want.long_press, want.volume_mode, got.step_valid,
                                 got.step_delta, got.step_is_volume, got.mode_toggled,
                                 got.long_press, got.volume_mode);
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int drain_cycles;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pin_a          = 1'b1;
        pin_b          = 1'b1;
        button_level   = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_LONG_PRESS;
        cfg_data       = '0;
        mismatch_count = 0;
        samples_taken  = 0;
        burst_left     = 0;
        walk_pos       = 2'd0;
        walk_dir       = 2'd1;
        btn_low        = 1'b0;
        btn_run        = 0;
        knob_prev_ab   = AB_IDLE;
        knob_acc       = '0;
        knob_vol_mode  = 1'b1;
        knob_held      = 1'b0;
        knob_hold_cnt  = '0;
        cfg_thresh     = LONG_PRESS_RESET;
        cfg_vol_step   = STEP_RESET;
        cfg_bri_step   = STEP_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
            else
                send_sample(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                            DIRECTED_ROWS[i].btn, DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].res);
        end

        // random phases, extremes among them
        run_phase(24'($urandom_range(1, 24)), 24'($urandom_range(0, 100)),
                  24'($urandom_range(0, 100)), PHASE_ITEMS);
        run_phase(24'd1, 24'd100, 24'd0, PHASE_ITEMS);
        run_phase(24'd0, {17'($urandom), 7'h7F},
                  {17'($urandom), 7'($urandom_range(101, 127))}, PHASE_ITEMS);
        run_phase(24'hFFFFFF, 24'd0, 24'd100, PHASE_ITEMS);
        run_phase(24'($urandom), 24'($urandom), 24'($urandom), PHASE_ITEMS);
        run_phase(24'($urandom_range(2, 40)), 24'($urandom_range(0, 127)),
                  24'($urandom_range(0, 127)), PHASE_ITEMS);

        // drain
        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/qkb_pkg.sv
rtl/qkb_engine.sv
rtl/quadrature_knob_with_mode_button_core.sv
rtl/qkb_checker.sv
dv/tb_quadrature_knob_with_mode_button_core.sv
